FILE: rtl/core/kzd_pkg.sv
`timescale 1ns / 1ps

package kzd_pkg;

  localparam int ZONE_SLOTS     = 64;
  localparam int DEBOUNCE_DEPTH = 3;
  localparam int ZONE_BASE      = 33;
  localparam int ARMED_LEVEL    = 2;

  localparam int ZONE_W  = 7;
  localparam int NODE_W  = 64;
  localparam int EP_W    = 16;
  localparam int ARM_W   = 3;
  localparam int SLOT_W  = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
  localparam int CNT_W   = $clog2(ZONE_SLOTS + 1);
  localparam int PTR_W   = $clog2(DEBOUNCE_DEPTH);

  typedef enum logic [1:0] {
    FN_REGISTER   = 2'd0,
    FN_UNREGISTER = 2'd1,
    FN_UPDATE     = 2'd2,
    FN_QUERY      = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LOOK
  } fsm_t;

  typedef struct packed {
    logic [NODE_W-1:0]         node;
    logic [EP_W-1:0]           ep;
    logic                      conf;
    logic [DEBOUNCE_DEPTH-1:0] ring;
    logic [PTR_W-1:0]          ptr;
    logic                      full;
  } entry_t;

endpackage

FILE: rtl/core/keyed_zone_debounce_table_top.sv
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// input     start high, busy low   in_func, in_zone_number, in_node_id, in_endpoint_id,
//                                  in_reading, in_arm_state
// result    out_valid, one cycle   out_status, out_zone_out, out_zone_state,
//                                  out_state_changed, out_alarm, out_active_mask,
//                                  out_active_count
//
// Register and out-of-range items give their result in the cycle after acceptance; unregister
// and query first wait on one read of the zone memory, then register their result.
// An update scans the key memory one slot a cycle and stops at the first slot whose key matches.
// Reset is synchronous and clears the active and written maps; the zone memory itself needs
// no clearing. The receiver cannot stall: each result stands for exactly one cycle.
module keyed_zone_debounce_table_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_func,
  input  logic [kzd_pkg::ZONE_W-1:0]   in_zone_number,
  input  logic [kzd_pkg::NODE_W-1:0]   in_node_id,
  input  logic [kzd_pkg::EP_W-1:0]     in_endpoint_id,
  input  logic                         in_reading,
  input  logic [kzd_pkg::ARM_W-1:0]    in_arm_state,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [kzd_pkg::ZONE_W-1:0]   out_zone_out,
  output logic                         out_zone_state,
  output logic                         out_state_changed,
  output logic                         out_alarm,
  output logic [kzd_pkg::ZONE_SLOTS-1:0] out_active_mask,
  output logic [kzd_pkg::CNT_W-1:0]    out_active_count
);
  import kzd_pkg::*;

  fsm_t                  state_r, state_nxt;
  logic [ZONE_SLOTS-1:0] active_r, active_nxt;
  logic [ZONE_SLOTS-1:0] touched_r, touched_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [SLOT_W:0]       scan_cnt_r, scan_cnt_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [SLOT_W-1:0]     cmp_slot_r;

  func_t                 func_r;
  logic [ZONE_W-1:0]     zone_r;
  logic [NODE_W-1:0]     node_r;
  logic [EP_W-1:0]       ep_r;
  logic                  rd_r;
  logic [ARM_W-1:0]      arm_r;

  entry_t                mem [ZONE_SLOTS];
  entry_t                mem_rdata_r;
  entry_t                mem_wdata;
  logic                  mem_we, mem_re;
  logic [SLOT_W-1:0]     mem_waddr, mem_raddr;

  logic                  out_valid_r, out_load;
  status_t               out_status_r, out_status_nxt;
  logic [ZONE_W-1:0]     out_zone_r, out_zone_nxt;
  logic                  out_zstate_r, out_zstate_nxt;
  logic                  out_changed_r, out_changed_nxt;
  logic                  out_alarm_r, out_alarm_nxt;

  logic                  accept;
  logic                  in_range, lat_range;
  logic [SLOT_W-1:0]     in_slot, lat_slot;
  logic                  match;
  logic [DEBOUNCE_DEPTH-1:0] ring_n;
  logic [PTR_W:0]        ptr_inc;
  logic [PTR_W-1:0]      ptr_n;
  logic                  full_n, same, changed;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign in_range  = ({1'b0, in_zone_number} >= (ZONE_W+1)'(ZONE_BASE)) &&
                     ({1'b0, in_zone_number} < (ZONE_W+1)'(ZONE_BASE + ZONE_SLOTS));
  assign in_slot   = SLOT_W'(in_zone_number - ZONE_W'(ZONE_BASE));
  assign lat_range = ({1'b0, zone_r} >= (ZONE_W+1)'(ZONE_BASE)) &&
                     ({1'b0, zone_r} < (ZONE_W+1)'(ZONE_BASE + ZONE_SLOTS));
  assign lat_slot  = SLOT_W'(zone_r - ZONE_W'(ZONE_BASE));

  assign match = cmp_vld_r && active_r[cmp_slot_r] &&
                 (mem_rdata_r.node == node_r) && (mem_rdata_r.ep == ep_r);

  always_comb begin
    ring_n          = mem_rdata_r.ring;
    ring_n[mem_rdata_r.ptr] = rd_r;
    ptr_inc         = {1'b0, mem_rdata_r.ptr} + (PTR_W+1)'(1);
    if (ptr_inc >= (PTR_W+1)'(DEBOUNCE_DEPTH)) begin
      ptr_n  = '0;
      full_n = 1'b1;
    end else begin
      ptr_n  = ptr_inc[PTR_W-1:0];
      full_n = mem_rdata_r.full;
    end
    same    = (ring_n == '0) || (ring_n == '1);
    changed = full_n && same && (mem_rdata_r.conf != rd_r);
  end

  always_comb begin
    state_nxt       = state_r;
    active_nxt      = active_r;
    touched_nxt     = touched_r;
    count_nxt       = count_r;
    scan_cnt_nxt    = scan_cnt_r;
    cmp_vld_nxt     = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = in_slot;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mem_raddr       = in_slot;
    out_load        = 1'b0;
    out_status_nxt  = ST_OK;
    out_zone_nxt    = '0;
    out_zstate_nxt  = 1'b0;
    out_changed_nxt = 1'b0;
    out_alarm_nxt   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (func_t'(in_func) == FN_UPDATE) begin
            scan_cnt_nxt = '0;
            state_nxt    = S_SCAN;
          end else if (!in_range) begin
            out_load       = 1'b1;
            out_status_nxt = ST_RANGE;
            out_zone_nxt   = in_zone_number;
          end else if (func_t'(in_func) == FN_REGISTER) begin
            mem_we               = 1'b1;
            mem_wdata.node       = in_node_id;
            mem_wdata.ep         = in_endpoint_id;
            active_nxt[in_slot]  = 1'b1;
            touched_nxt[in_slot] = 1'b1;
            if (!active_r[in_slot]) begin
              count_nxt = count_r + CNT_W'(1);
            end
            out_load     = 1'b1;
            out_zone_nxt = in_zone_number;
          end else begin
            mem_re    = 1'b1;
            state_nxt = S_LOOK;
          end
        end
      end
      S_SCAN: begin
        if (match) begin
          mem_we          = 1'b1;
          mem_waddr       = cmp_slot_r;
          mem_wdata       = mem_rdata_r;
          mem_wdata.ring  = ring_n;
          mem_wdata.ptr   = ptr_n;
          mem_wdata.full  = full_n;
          mem_wdata.conf  = changed ? rd_r : mem_rdata_r.conf;
          out_load        = 1'b1;
          out_zone_nxt    = ZONE_W'(ZONE_BASE) + ZONE_W'(cmp_slot_r);
          out_zstate_nxt  = changed ? rd_r : mem_rdata_r.conf;
          out_changed_nxt = changed;
          out_alarm_nxt   = changed && rd_r && (arm_r >= ARM_W'(ARMED_LEVEL));
          state_nxt       = S_IDLE;
        end else if (scan_cnt_r < (SLOT_W+1)'(ZONE_SLOTS)) begin
          mem_re       = 1'b1;
          mem_raddr    = scan_cnt_r[SLOT_W-1:0];
          scan_cnt_nxt = scan_cnt_r + (SLOT_W+1)'(1);
          cmp_vld_nxt  = 1'b1;
        end else begin
          out_load       = 1'b1;
          out_status_nxt = ST_MISSING;
          state_nxt      = S_IDLE;
        end
      end
      S_LOOK: begin
        out_load     = 1'b1;
        out_zone_nxt = zone_r;
        if (func_r == FN_UNREGISTER) begin
          active_nxt[lat_slot] = 1'b0;
          if (active_r[lat_slot]) begin
            count_nxt = count_r - CNT_W'(1);
          end
          out_zstate_nxt = touched_r[lat_slot] && mem_rdata_r.conf;
        end else if (!active_r[lat_slot] || !lat_range) begin
          out_status_nxt = ST_MISSING;
        end else begin
          out_zstate_nxt = mem_rdata_r.conf;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      touched_r   <= '0;
      count_r     <= '0;
      scan_cnt_r  <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      touched_r   <= touched_nxt;
      count_r     <= count_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= func_t'(in_func);
      zone_r <= in_zone_number;
      node_r <= in_node_id;
      ep_r   <= in_endpoint_id;
      rd_r   <= in_reading;
      arm_r  <= in_arm_state;
    end
    if (mem_re) begin
      cmp_slot_r <= mem_raddr;
    end
    if (out_load) begin
      out_status_r  <= out_status_nxt;
      out_zone_r    <= out_zone_nxt;
      out_zstate_r  <= out_zstate_nxt;
      out_changed_r <= out_changed_nxt;
      out_alarm_r   <= out_alarm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_zone_out      = out_zone_r;
  assign out_zone_state    = out_zstate_r;
  assign out_state_changed = out_changed_r;
  assign out_alarm         = out_alarm_r;
  assign out_active_mask   = active_r;
  assign out_active_count  = count_r;

`ifndef SYNTHESIS
  a_count_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(active_r)))
    else $error("active count disagrees with the active map");

  a_active_written: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r & ~touched_r) == '0)
    else $error("active zone has never been written");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while an item is still at work");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result without an accepted item");
`endif

endmodule
